// ===== rtl/tpo_pkg.sv =====
package tpo_pkg;

  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_START   = 3'd1;
  localparam logic [2:0] CMD_STOP    = 3'd2;
  localparam logic [2:0] CMD_CHECK   = 3'd3;
  localparam logic [2:0] CMD_RESTART = 3'd4;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_ZERO_PERIOD = 3'd1;
  localparam logic [2:0] ST_FULL        = 3'd2;
  localparam logic [2:0] ST_BAD_ID      = 3'd3;
  localparam logic [2:0] ST_INACTIVE    = 3'd4;

  localparam logic [7:0] DEFAULT_SLOTS = 8'd4;
  localparam logic [7:0] RESET_SLOTS   = 8'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_TICK,
    S_DRAIN,
    S_SCAN,
    S_RLD,
    S_RLD_WB,
    S_RESP
  } state_e;

  typedef struct packed {
    logic       in_fire;
    logic [2:0] cmd;
    logic       period_zero;
    logic       id_bad;
    logic       id_active;
    logic       scan_free;
    logic       idx_last;
    logic       out_free;
  } seq_in_t;

endpackage

// ===== rtl/tpo_ram.sv =====
module tpo_ram #(
  parameter int Width = 32,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tpo_seq.sv =====
module tpo_seq #(
  parameter int IdxW = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tpo_pkg::seq_in_t sin_i,
  output tpo_pkg::state_e  state_o,
  output logic [IdxW-1:0]  idx_o
);
  import tpo_pkg::*;

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (sin_i.in_fire) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (sin_i.cmd)
          CMD_TICK:    state_d = S_TICK;
          CMD_START:   state_d = sin_i.period_zero ? S_RESP : S_SCAN;
          CMD_RESTART: state_d = (sin_i.id_bad || !sin_i.id_active) ? S_RESP : S_RLD;
          default:     state_d = S_RESP;
        endcase
      end
      S_TICK: begin
        if (sin_i.idx_last) state_d = S_DRAIN;
      end
      S_DRAIN:  state_d = S_RESP;
      S_SCAN: begin
        if (sin_i.scan_free || sin_i.idx_last) state_d = S_RESP;
      end
      S_RLD:    state_d = S_RLD_WB;
      S_RLD_WB: state_d = S_RESP;
      S_RESP: begin
        if (sin_i.out_free) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    case (state_q)
      S_DECODE: idx_d = '0;
      S_TICK:   idx_d = idx_q + IdxW'(1);
      S_SCAN:   idx_d = idx_q + IdxW'(1);
      default:  idx_d = idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign state_o = state_q;
  assign idx_o   = idx_q;

endmodule

// ===== rtl/timer_pool_once_auto_core.sv =====
// Accept to result valid: tick sweeps the n enabled slots, one slot per cycle through the
// shared decrement unit, then drains; start scans for a free slot (not for a zero period);
// restart reads the reload memory into the count memory; stop/check/other respond directly.
// Items are not overlapped; the next item is taken the cycle after the
// result register is loaded, and a stalled result holds the sequencer in its response state.
// Reset (async, active low) clears slot active/mode/flag bits, the sequencer, out valid and
// sets active_slots to 4; count/reload memories are not reset and only used for active slots.
module timer_pool_once_auto_core #(
  parameter int NUM_TIMERS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [7:0]  timer_id_i,
  input  logic [31:0] period_i,
  input  logic        timer_mode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  slot_id_o,
  output logic        expired_o
);
  import tpo_pkg::*;

  localparam int IdxW = $clog2(NUM_TIMERS);

  logic [7:0]            active_slots_q;
  logic [7:0]            n_slots;
  logic [2:0]            cmd_q;
  logic [7:0]            timer_id_q;
  logic [31:0]           period_q;
  logic                  mode_q;
  logic [2:0]            res_status_q;
  logic [7:0]            res_slot_q;
  logic                  res_exp_q;
  logic                  out_valid_q;
  logic [2:0]            status_q;
  logic [7:0]            slot_id_q;
  logic                  expired_q;
  logic [NUM_TIMERS-1:0] active_q;
  logic [NUM_TIMERS-1:0] smode_q;
  logic [NUM_TIMERS-1:0] flag_q;
  logic                  wb_vld_q;
  logic [IdxW-1:0]       wb_idx_q;

  state_e          state;
  logic [IdxW-1:0] idx;
  logic [IdxW-1:0] id_idx;
  seq_in_t         sin;
  logic            in_fire, out_free, id_bad, scan_free;

  logic            cnt_we;
  logic [IdxW-1:0] cnt_waddr;
  logic [31:0]     cnt_wdata, cnt_rdata;
  logic            rld_we;
  logic [IdxW-1:0] rld_raddr;
  logic [31:0]     rld_rdata;
  logic [31:0]     cnt_dec;
  logic            tick_hit, tick_zero;
  logic [31:0]     tick_new;

  always_comb begin
    if (active_slots_q == 8'd0) begin
      n_slots = DEFAULT_SLOTS;
    end else if (active_slots_q > 8'(NUM_TIMERS)) begin
      n_slots = 8'(NUM_TIMERS);
    end else begin
      n_slots = active_slots_q;
    end
  end

  assign in_fire     = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign id_idx      = timer_id_q[IdxW-1:0];
  assign id_bad      = (timer_id_q >= n_slots);
  assign scan_free   = !active_q[idx];

  assign sin.in_fire     = in_fire;
  assign sin.cmd         = cmd_q;
  assign sin.period_zero = (period_q == 32'd0);
  assign sin.id_bad      = id_bad;
  assign sin.id_active   = active_q[id_idx];
  assign sin.scan_free   = scan_free;
  assign sin.idx_last    = (8'(idx) == n_slots - 8'd1);
  assign sin.out_free    = out_free;

  tpo_seq #(.IdxW(IdxW)) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sin_i   (sin),
    .state_o (state),
    .idx_o   (idx)
  );

  // shared decrement/compare unit
  assign cnt_dec   = cnt_rdata - 32'd1;
  assign tick_hit  = wb_vld_q && active_q[wb_idx_q] && (cnt_rdata != 32'd0);
  assign tick_zero = (cnt_dec == 32'd0);
  assign tick_new  = tick_zero ? (smode_q[wb_idx_q] ? rld_rdata : 32'd0) : cnt_dec;

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = idx;
    cnt_wdata = period_q;
    if (tick_hit) begin
      cnt_we    = 1'b1;
      cnt_waddr = wb_idx_q;
      cnt_wdata = tick_new;
    end else begin
      case (state)
        S_DECODE: begin
          if (cmd_q == CMD_STOP && !id_bad) begin
            cnt_we    = 1'b1;
            cnt_waddr = id_idx;
            cnt_wdata = 32'd0;
          end
        end
        S_SCAN: begin
          cnt_we = scan_free;
        end
        S_RLD_WB: begin
          cnt_we    = 1'b1;
          cnt_waddr = id_idx;
          cnt_wdata = rld_rdata;
        end
        default: cnt_we = 1'b0;
      endcase
    end
  end

  assign rld_we    = (state == S_SCAN) && scan_free;
  assign rld_raddr = (state == S_RLD) ? id_idx : idx;

  tpo_ram #(.Width(32), .Depth(NUM_TIMERS)) u_count (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (idx),
    .rdata_o (cnt_rdata)
  );

  tpo_ram #(.Width(32), .Depth(NUM_TIMERS)) u_reload (
    .clk_i   (clk_i),
    .we_i    (rld_we),
    .waddr_i (idx),
    .wdata_i (period_q),
    .raddr_i (rld_raddr),
    .rdata_o (rld_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_slots_q <= RESET_SLOTS;
      wb_vld_q       <= 1'b0;
      wb_idx_q       <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) active_slots_q <= cfg_data_i;
      wb_vld_q <= (state == S_TICK);
      wb_idx_q <= idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      smode_q  <= '0;
      flag_q   <= '0;
    end else begin
      if (tick_hit && tick_zero) flag_q[wb_idx_q] <= 1'b1;
      case (state)
        S_DECODE: begin
          if (!id_bad && cmd_q == CMD_STOP) begin
            active_q[id_idx] <= 1'b0;
            flag_q[id_idx]   <= 1'b0;
          end
          if (!id_bad && cmd_q == CMD_CHECK && active_q[id_idx] && flag_q[id_idx]) begin
            flag_q[id_idx] <= 1'b0;
            if (!smode_q[id_idx]) active_q[id_idx] <= 1'b0;
          end
        end
        S_SCAN: begin
          if (scan_free) begin
            active_q[idx] <= 1'b1;
            smode_q[idx]  <= mode_q;
            flag_q[idx]   <= 1'b0;
          end
        end
        S_RLD_WB: flag_q[id_idx] <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q        <= command_i;
      timer_id_q   <= timer_id_i;
      period_q     <= period_i;
      mode_q       <= timer_mode_i;
      res_status_q <= ST_OK;
      res_slot_q   <= 8'd0;
      res_exp_q    <= 1'b0;
    end else begin
      case (state)
        S_DECODE: begin
          case (cmd_q)
            CMD_START: begin
              if (period_q == 32'd0) res_status_q <= ST_ZERO_PERIOD;
            end
            CMD_STOP: begin
              if (id_bad) res_status_q <= ST_BAD_ID;
            end
            CMD_CHECK, CMD_RESTART: begin
              if (id_bad) begin
                res_status_q <= ST_BAD_ID;
              end else if (!active_q[id_idx]) begin
                res_status_q <= ST_INACTIVE;
              end else if (cmd_q == CMD_CHECK) begin
                res_exp_q <= flag_q[id_idx];
              end
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          if (scan_free) begin
            res_slot_q <= 8'(idx);
          end else if (sin.idx_last) begin
            res_status_q <= ST_FULL;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state == S_RESP && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state == S_RESP && out_free) begin
      status_q  <= res_status_q;
      slot_id_q <= res_slot_q;
      expired_q <= res_exp_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_id_o   = slot_id_q;
  assign expired_o   = expired_q;

  a_wb_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_vld_q |-> (state == S_TICK || state == S_DRAIN))
    else $error("tick writeback outside sweep");

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state == S_DECODE))
    else $error("accepted beat not decoded");

  a_expired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && expired_o) |-> (status_o == ST_OK))
    else $error("expired with error status");

  a_slot_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && slot_id_o != 8'd0) |-> (status_o == ST_OK))
    else $error("slot id with error status");

  a_load_on_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state == S_RESP))
    else $error("result loaded outside response state");

endmodule
